FILE: rtl/core/rrct_pkg.sv
`default_nettype none
package rrct_pkg;

  localparam int OFS_W   = 26;  // corner offset from pivot, pixels * 256
  localparam int PIV_W   = 25;  // pivot point, pixels * 256
  localparam int ANG_W   = 32;  // CORDIC angle, degrees * 2^22
  localparam int CS_W    = 34;  // cosine / sine, Q30 with headroom
  localparam int SCALE_W = 24;
  localparam int OUT_W   = 32;

  localparam logic signed [16:0] TURN_UNITS    = 17'sd23040;
  localparam logic signed [16:0] HALF_UNITS    = 17'sd11520;
  localparam logic signed [16:0] QUARTER_UNITS = 17'sd5760;

  typedef struct packed {
    logic signed [OFS_W-1:0] left;
    logic signed [OFS_W-1:0] right;
    logic signed [OFS_W-1:0] top;
    logic signed [OFS_W-1:0] bottom;
    logic signed [PIV_W-1:0] rpx;
    logic signed [PIV_W-1:0] rpy;
    logic [SCALE_W-1:0]      scale;
  } geom_t;

  // Arctangent of 2^-i in CORDIC angle units
  function automatic logic signed [ANG_W-1:0] atan_val(input int i);
    logic signed [ANG_W-1:0] r;
    begin
      case (i)
        0:  r = 32'sd188743680;
        1:  r = 32'sd111421900;
        2:  r = 32'sd58872272;
        3:  r = 32'sd29884485;
        4:  r = 32'sd15000234;
        5:  r = 32'sd7507429;
        6:  r = 32'sd3754631;
        7:  r = 32'sd1877430;
        8:  r = 32'sd938729;
        9:  r = 32'sd469366;
        10: r = 32'sd234683;
        11: r = 32'sd117342;
        12: r = 32'sd58671;
        13: r = 32'sd29335;
        14: r = 32'sd14668;
        15: r = 32'sd7334;
        16: r = 32'sd3667;
        17: r = 32'sd1833;
        18: r = 32'sd917;
        19: r = 32'sd458;
        20: r = 32'sd229;
        21: r = 32'sd115;
        22: r = 32'sd57;
        default: r = 32'sd29;
      endcase
      return r;
    end
  endfunction

  // CORDIC start value (inverse gain, Q30) for a given stage count
  function automatic logic signed [CS_W-1:0] gain_val(input int n);
    logic signed [CS_W-1:0] r;
    begin
      case (n)
        8:  r = 34'sd652039507;
        9:  r = 34'sd652034532;
        10: r = 34'sd652033289;
        11: r = 34'sd652032978;
        12: r = 34'sd652032900;
        13: r = 34'sd652032881;
        14: r = 34'sd652032876;
        default: r = 34'sd652032874;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/rotated_rect_corner_transform.sv
// Throughput: one word per cycle; busy is always low. The pipeline depth is
// set by one CORDIC micro-rotation per register stage.
// Reset (rst, synchronous) clears all valid bits; no done strobe follows it.
// done is high for one cycle per word and cannot be held off.
`default_nettype none
module rotated_rect_corner_transform #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic signed [23:0] pivot_x,
  input  logic signed [23:0] pivot_y,
  input  logic signed [15:0] angle,
  input  logic [23:0]        scale,
  input  logic [15:0]        width_px,
  input  logic [15:0]        height_px,
  input  logic [15:0]        trim_top,
  input  logic [15:0]        trim_right,
  input  logic [15:0]        trim_bottom,
  input  logic [15:0]        trim_left,
  output logic               done,
  output logic signed [31:0] corner_a_x,
  output logic signed [31:0] corner_a_y,
  output logic signed [31:0] corner_b_x,
  output logic signed [31:0] corner_b_y,
  output logic signed [31:0] corner_c_x,
  output logic signed [31:0] corner_c_y,
  output logic signed [31:0] corner_d_x,
  output logic signed [31:0] corner_d_y
);

  localparam int CORNER_DEPTH = 4;

  logic                              prep_valid;
  logic signed [rrct_pkg::ANG_W-1:0] prep_z;
  logic                              prep_flip;
  rrct_pkg::geom_t                   prep_geom;
  logic                              cs_valid;
  logic signed [rrct_pkg::CS_W-1:0]  cos_v, sin_v;
  rrct_pkg::geom_t                   geom;
  logic [CORNER_DEPTH-1:0]           vld_sr;

  assign busy = 1'b0;

  rrct_prep u_prep (
    .clk, .rst,
    .in_valid (start),
    .pos_x, .pos_y, .pivot_x, .pivot_y, .angle, .scale,
    .width_px, .height_px, .trim_top, .trim_right, .trim_bottom, .trim_left,
    .out_valid (prep_valid),
    .z         (prep_z),
    .flip      (prep_flip),
    .geom      (prep_geom)
  );

  rrct_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
    .clk, .rst,
    .in_valid  (prep_valid),
    .z_in      (prep_z),
    .flip_in   (prep_flip),
    .geom_in   (prep_geom),
    .out_valid (cs_valid),
    .cos_q     (cos_v),
    .sin_q     (sin_v),
    .geom_out  (geom)
  );

  rrct_corner u_a (.clk, .dx(geom.left), .dy(geom.top), .cos_v, .sin_v,
    .scale(geom.scale), .rpx(geom.rpx), .rpy(geom.rpy), .ox(corner_a_x), .oy(corner_a_y));
  rrct_corner u_b (.clk, .dx(geom.right), .dy(geom.top), .cos_v, .sin_v,
    .scale(geom.scale), .rpx(geom.rpx), .rpy(geom.rpy), .ox(corner_b_x), .oy(corner_b_y));
  rrct_corner u_c (.clk, .dx(geom.right), .dy(geom.bottom), .cos_v, .sin_v,
    .scale(geom.scale), .rpx(geom.rpx), .rpy(geom.rpy), .ox(corner_c_x), .oy(corner_c_y));
  rrct_corner u_d (.clk, .dx(geom.left), .dy(geom.bottom), .cos_v, .sin_v,
    .scale(geom.scale), .rpx(geom.rpx), .rpy(geom.rpy), .ox(corner_d_x), .oy(corner_d_y));

  // Advance valid alongside the corner pipelines
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_sr <= '0;
    end else begin
      vld_sr <= {vld_sr[CORNER_DEPTH-2:0], cs_valid};
    end
  end

  assign done = vld_sr[CORNER_DEPTH-1];

endmodule
`default_nettype wire

FILE: rtl/core/rrct_prep.sv
`default_nettype none
module rrct_prep (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic signed [23:0]             pos_x,
  input  logic signed [23:0]             pos_y,
  input  logic signed [23:0]             pivot_x,
  input  logic signed [23:0]             pivot_y,
  input  logic signed [15:0]             angle,
  input  logic [23:0]                    scale,
  input  logic [15:0]                    width_px,
  input  logic [15:0]                    height_px,
  input  logic [15:0]                    trim_top,
  input  logic [15:0]                    trim_right,
  input  logic [15:0]                    trim_bottom,
  input  logic [15:0]                    trim_left,
  output logic                           out_valid,
  output logic signed [rrct_pkg::ANG_W-1:0] z,
  output logic                           flip,
  output rrct_pkg::geom_t                geom
);

  logic signed [16:0] a_half;
  logic signed [16:0] a_fold;
  logic               flip_next;
  logic signed [16:0] w_span;
  logic signed [16:0] h_span;
  rrct_pkg::geom_t    geom_next;

  // Reduce angle to a half turn either side, then fold into a quarter turn
  always_comb begin
    a_half = 17'(angle);
    if (a_half >= rrct_pkg::HALF_UNITS)
      a_half = a_half - rrct_pkg::TURN_UNITS;
    else if (a_half < -rrct_pkg::HALF_UNITS)
      a_half = a_half + rrct_pkg::TURN_UNITS;
    a_fold    = a_half;
    flip_next = 1'b0;
    if (a_half > rrct_pkg::QUARTER_UNITS) begin
      a_fold    = a_half - rrct_pkg::HALF_UNITS;
      flip_next = 1'b1;
    end else if (a_half < -rrct_pkg::QUARTER_UNITS) begin
      a_fold    = a_half + rrct_pkg::HALF_UNITS;
      flip_next = 1'b1;
    end
  end

  // Form cropped edge offsets from the pivot and the pivot point
  always_comb begin
    w_span = $signed({1'b0, width_px}) - $signed({1'b0, trim_right});
    h_span = $signed({1'b0, trim_bottom}) - $signed({1'b0, height_px});
    geom_next.left   = $signed({2'b00, trim_left, 8'h00}) - 26'(pivot_x);
    geom_next.right  = $signed({w_span[16], w_span, 8'h00}) - 26'(pivot_x);
    geom_next.top    = -$signed({2'b00, trim_top, 8'h00}) - 26'(pivot_y);
    geom_next.bottom = $signed({h_span[16], h_span, 8'h00}) - 26'(pivot_y);
    geom_next.rpx    = 25'(pos_x) + 25'(pivot_x);
    geom_next.rpy    = 25'(pos_y) + 25'(pivot_y);
    geom_next.scale  = scale;
  end

  // The folded angle fits 16 bits, so its low bits carry the sign into z
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    z    <= {a_fold[rrct_pkg::ANG_W-17:0], 16'h0000};
    flip <= flip_next;
    geom <= geom_next;
  end

endmodule
`default_nettype wire

FILE: rtl/core/rrct_cordic.sv
`default_nettype none
module rrct_cordic #(
  parameter int STAGES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic signed [rrct_pkg::ANG_W-1:0] z_in,
  input  logic                              flip_in,
  input  rrct_pkg::geom_t                   geom_in,
  output logic                              out_valid,
  output logic signed [rrct_pkg::CS_W-1:0]  cos_q,
  output logic signed [rrct_pkg::CS_W-1:0]  sin_q,
  output rrct_pkg::geom_t                   geom_out
);

  localparam logic signed [rrct_pkg::CS_W-1:0] GAIN = rrct_pkg::gain_val(STAGES);

  logic signed [rrct_pkg::CS_W-1:0]  x_q [STAGES];
  logic signed [rrct_pkg::CS_W-1:0]  y_q [STAGES];
  logic signed [rrct_pkg::ANG_W-1:0] z_q [STAGES];
  logic                              v_q [STAGES];
  logic                              f_q [STAGES];
  rrct_pkg::geom_t                   g_q [STAGES];

  // Valid bits advance one micro-rotation per stage
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STAGES; i++) v_q[i] <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v_q[0] <= in_valid;
      for (int i = 1; i < STAGES; i++) v_q[i] <= v_q[i-1];
      out_valid <= v_q[STAGES-1];
    end
  end

  // One micro-rotation per register stage
  always_ff @(posedge clk) begin
    x_q[0] <= GAIN;
    if (!z_in[rrct_pkg::ANG_W-1]) begin
      y_q[0] <= GAIN;
      z_q[0] <= z_in - rrct_pkg::atan_val(0);
    end else begin
      y_q[0] <= -GAIN;
      z_q[0] <= z_in + rrct_pkg::atan_val(0);
    end
    f_q[0] <= flip_in;
    g_q[0] <= geom_in;
    for (int i = 1; i < STAGES; i++) begin
      if (!z_q[i-1][rrct_pkg::ANG_W-1]) begin
        x_q[i] <= x_q[i-1] - (y_q[i-1] >>> i);
        y_q[i] <= y_q[i-1] + (x_q[i-1] >>> i);
        z_q[i] <= z_q[i-1] - rrct_pkg::atan_val(i);
      end else begin
        x_q[i] <= x_q[i-1] + (y_q[i-1] >>> i);
        y_q[i] <= y_q[i-1] - (x_q[i-1] >>> i);
        z_q[i] <= z_q[i-1] + rrct_pkg::atan_val(i);
      end
      f_q[i] <= f_q[i-1];
      g_q[i] <= g_q[i-1];
    end
    // Undo the half-turn fold
    cos_q    <= f_q[STAGES-1] ? -x_q[STAGES-1] : x_q[STAGES-1];
    sin_q    <= f_q[STAGES-1] ? -y_q[STAGES-1] : y_q[STAGES-1];
    geom_out <= g_q[STAGES-1];
  end

endmodule
`default_nettype wire

FILE: rtl/core/rrct_corner.sv
`default_nettype none
module rrct_corner (
  input  logic                                clk,
  input  logic signed [rrct_pkg::OFS_W-1:0]   dx,
  input  logic signed [rrct_pkg::OFS_W-1:0]   dy,
  input  logic signed [rrct_pkg::CS_W-1:0]    cos_v,
  input  logic signed [rrct_pkg::CS_W-1:0]    sin_v,
  input  logic [rrct_pkg::SCALE_W-1:0]        scale,
  input  logic signed [rrct_pkg::PIV_W-1:0]   rpx,
  input  logic signed [rrct_pkg::PIV_W-1:0]   rpy,
  output logic signed [rrct_pkg::OUT_W-1:0]   ox,
  output logic signed [rrct_pkg::OUT_W-1:0]   oy
);

  localparam int P_W = rrct_pkg::OFS_W + rrct_pkg::CS_W;  // 60
  localparam int S_W = P_W + 1;
  localparam int R_W = 28;
  localparam int Z_W = R_W + rrct_pkg::SCALE_W + 1;      // 53
  localparam int F_W = 38;

  logic signed [P_W-1:0] p_xc, p_ys, p_yc, p_xs;
  logic signed [S_W-1:0] sum_x, sum_y;
  logic signed [R_W-1:0] rx, ry;
  logic signed [Z_W-1:0] zp_x, zp_y;
  logic signed [F_W-1:0] fx, fy;
  logic [rrct_pkg::SCALE_W-1:0]      scale_d1, scale_d2;
  logic signed [rrct_pkg::PIV_W-1:0] rpx_d1, rpx_d2, rpx_d3;
  logic signed [rrct_pkg::PIV_W-1:0] rpy_d1, rpy_d2, rpy_d3;

  // Round the rotated sums and the zoomed values, then add the pivot back
  always_comb begin
    sum_x = S_W'(p_xc) - S_W'(p_ys) + (S_W'(1) <<< 29);
    sum_y = S_W'(p_yc) + S_W'(p_xs) + (S_W'(1) <<< 29);
    fx = F_W'((zp_x + Z_W'(32768)) >>> 16) + F_W'(rpx_d3);
    fy = F_W'((zp_y + Z_W'(32768)) >>> 16) + F_W'(rpy_d3);
  end

  function automatic logic signed [rrct_pkg::OUT_W-1:0] sat(input logic signed [F_W-1:0] v);
    logic signed [rrct_pkg::OUT_W-1:0] r;
    begin
      if (v > F_W'(32'sh7fffffff))       r = 32'sh7fffffff;
      else if (v < -F_W'(33'sh080000000)) r = 32'sh80000000;
      else                               r = v[rrct_pkg::OUT_W-1:0];
      return r;
    end
  endfunction

  always_ff @(posedge clk) begin
    // rotate: four products
    p_xc <= dx * cos_v;
    p_ys <= dy * sin_v;
    p_yc <= dy * cos_v;
    p_xs <= dx * sin_v;
    scale_d1 <= scale;
    rpx_d1 <= rpx;
    rpy_d1 <= rpy;
    // drop Q30 fraction
    rx <= R_W'(sum_x >>> 30);
    ry <= R_W'(sum_y >>> 30);
    scale_d2 <= scale_d1;
    rpx_d2 <= rpx_d1;
    rpy_d2 <= rpy_d1;
    // zoom
    zp_x <= rx * $signed({1'b0, scale_d2});
    zp_y <= ry * $signed({1'b0, scale_d2});
    rpx_d3 <= rpx_d2;
    rpy_d3 <= rpy_d2;
    // saturate
    ox <= sat(fx);
    oy <= sat(fy);
  end

endmodule
`default_nettype wire

FILE: sim/tb_rotated_rect_corner_transform.sv
`default_nettype none
typedef struct {
  logic signed [31:0] ax, ay, bx, by, cx, cy, dx, dy;
} corners_t;

class corner_scoreboard;
  corners_t pending_corners[$];
  int errors;
  int checked;

  function new();
    errors = 0;
    checked = 0;
  endfunction

  // Floor shift right of a signed 64-bit value
  static function longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  static function logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Work out sine and cosine (Q30) for an angle in degrees * 64
  static function void rotation_terms(longint ang, output longint cosv, output longint sinv);
    longint a, x, y, z, xs, ys;
    bit flip;
    longint atans[16];
    atans = '{188743680, 111421900, 58872272, 29884485, 15000234, 7507429, 3754631,
              1877430, 938729, 469366, 234683, 117342, 58671, 29335, 14668, 7334};
    flip = 0;
    a = ang % 23040;
    if (a < 0) a += 23040;
    if (a >= 11520) a -= 23040;
    if (a > 5760) begin
      a -= 11520;
      flip = 1;
    end
    if (a < -5760) begin
      a += 11520;
      flip = 1;
    end
    x = 652032874;
    y = 0;
    z = a * 65536;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= atans[i];
      end else begin
        x += ys; y -= xs; z += atans[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    cosv = x;
    sinv = y;
  endfunction

  static function void place_corner(longint ox, longint oy, longint cosv, longint sinv,
      longint zoom, longint px, longint py, output logic signed [31:0] rx_o,
      output logic signed [31:0] ry_o);
    longint rx, ry;
    rx = (ox * cosv - oy * sinv + (64'sd1 <<< 29)) >>> 30;
    ry = (oy * cosv + ox * sinv + (64'sd1 <<< 29)) >>> 30;
    rx_o = clamp32(((rx * zoom + 32768) >>> 16) + px);
    ry_o = clamp32(((ry * zoom + 32768) >>> 16) + py);
  endfunction

  // Note an accepted word and queue the corners it should produce
  function void note_word(longint pos_x, pos_y, pivot_x, pivot_y, angle, scale,
      longint w, h, tt, tr, tb, tl);
    corners_t c;
    longint px, py, left, right, top, bottom, cosv, sinv;
    px = pos_x + pivot_x;
    py = pos_y + pivot_y;
    left = tl * 256 - pivot_x;
    right = (w - tr) * 256 - pivot_x;
    top = -tt * 256 - pivot_y;
    bottom = (tb - h) * 256 - pivot_y;
    rotation_terms(angle, cosv, sinv);
    place_corner(left, top, cosv, sinv, scale, px, py, c.ax, c.ay);
    place_corner(right, top, cosv, sinv, scale, px, py, c.bx, c.by);
    place_corner(right, bottom, cosv, sinv, scale, px, py, c.cx, c.cy);
    place_corner(left, bottom, cosv, sinv, scale, px, py, c.dx, c.dy);
    pending_corners.push_back(c);
  endfunction

  function void cmp(string name, logic signed [31:0] e, logic signed [31:0] a);
    if (e !== a) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      errors++;
    end
  endfunction

  // Check one result word against the oldest expectation
  function void check_word(corners_t got);
    corners_t e;
    if (pending_corners.size() == 0) begin
      $error("result word with no expectation pending");
      errors++;
      return;
    end
    e = pending_corners.pop_front();
    checked++;
    cmp("corner_a_x", e.ax, got.ax);
    cmp("corner_a_y", e.ay, got.ay);
    cmp("corner_b_x", e.bx, got.bx);
    cmp("corner_b_y", e.by, got.by);
    cmp("corner_c_x", e.cx, got.cx);
    cmp("corner_c_y", e.cy, got.cy);
    cmp("corner_d_x", e.dx, got.dx);
    cmp("corner_d_y", e.dy, got.dy);
  endfunction
endclass

module tb_rotated_rect_corner_transform;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 22;
  localparam int CYCLE_LIMIT = 200000;

  logic clk, rst, start, busy, done;
  logic signed [23:0] pos_x, pos_y, pivot_x, pivot_y;
  logic signed [15:0] angle;
  logic [23:0] scale;
  logic [15:0] width_px, height_px, trim_top, trim_right, trim_bottom, trim_left;
  logic signed [31:0] corner_a_x, corner_a_y, corner_b_x, corner_b_y;
  logic signed [31:0] corner_c_x, corner_c_y, corner_d_x, corner_d_y;

  corner_scoreboard board;
  int cycles;
  int idle_pct;
  int words_sent;

  rotated_rect_corner_transform dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Watchdog on total cycles
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_rotated_rect_corner_transform: FAIL");
      $finish;
    end
  end

  // Check result words as they strobe out
  always @(posedge clk) begin
    corners_t got;
    if (!rst && done) begin
      got.ax = corner_a_x; got.ay = corner_a_y;
      got.bx = corner_b_x; got.by = corner_b_y;
      got.cx = corner_c_x; got.cy = corner_c_y;
      got.dx = corner_d_x; got.dy = corner_d_y;
      board.check_word(got);
    end
  end

  // Present one word, idle at random first, hold until accepted
  task automatic send_word(logic [23:0] px, py, vx, vy, logic [15:0] ang,
      logic [23:0] zm, logic [15:0] w, h, tt, tr, tb, tl);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    pos_x <= px; pos_y <= py; pivot_x <= vx; pivot_y <= vy;
    angle <= ang; scale <= zm; width_px <= w; height_px <= h;
    trim_top <= tt; trim_right <= tr; trim_bottom <= tb; trim_left <= tl;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_word($signed(px), $signed(py), $signed(vx), $signed(vy), $signed(ang),
                    zm, w, h, tt, tr, tb, tl);
    words_sent++;
  endtask

  // Random word: mostly moderate geometry, some full-range noise
  task automatic send_random();
    if ($urandom_range(3) == 0)
      send_word(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                16'($urandom), 24'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    else
      send_word(24'($urandom_range(200000) - 100000), 24'($urandom_range(200000) - 100000),
                24'($urandom_range(40000) - 20000), 24'($urandom_range(40000) - 20000),
                16'($urandom_range(46079) - 23040), 24'($urandom_range(200000)),
                16'($urandom_range(2000)), 16'($urandom_range(2000)),
                16'($urandom_range(300)), 16'($urandom_range(300)),
                16'($urandom_range(300)), 16'($urandom_range(300)));
  endtask

  initial begin
    board = new();
    words_sent = 0;
    idle_pct = 37;
    rst = 1'b1;
    start = 1'b0;
    {pos_x, pos_y, pivot_x, pivot_y} = '0;
    {angle, scale, width_px, height_px} = '0;
    {trim_top, trim_right, trim_bottom, trim_left} = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, every quadrant, wrap-around, folds, zero zoom, overflow
    send_word(0, 0, 0, 0, 0, 24'h010000, 100, 50, 0, 0, 0, 0);
    send_word(1000, -2000, 256, 512, 5760, 24'h010000, 100, 50, 0, 0, 0, 0);
    send_word(1000, -2000, 256, 512, 11520, 24'h010000, 100, 50, 0, 0, 0, 0);
    send_word(1000, -2000, 256, 512, -5760, 24'h010000, 100, 50, 0, 0, 0, 0);
    send_word(1000, -2000, 256, 512, -11520, 24'h010000, 100, 50, 0, 0, 0, 0);
    send_word(5, 5, 0, 0, 16'sh7fff, 24'h020000, 10, 10, 1, 2, 3, 4);
    send_word(5, 5, 0, 0, 16'sh8000, 24'h008000, 10, 10, 1, 2, 3, 4);
    send_word(5, 5, 0, 0, 23039, 24'h010000, 10, 10, 0, 0, 0, 0);
    send_word(5, 5, 0, 0, -23040, 24'h010000, 10, 10, 0, 0, 0, 0);
    send_word(5, 5, 0, 0, 100, 24'h010000, 10, 10, 30, 40, 50, 60);
    send_word(-300, 77, 900, -900, 1234, 24'h000000, 500, 500, 3, 3, 3, 3);
    send_word(24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff, 2880, 24'hffffff,
              16'hffff, 16'hffff, 0, 0, 0, 0);
    send_word(24'h800000, 24'h800000, 24'h800000, 24'h800000, -2880, 24'hffffff,
              16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_word(24'h7fffff, 24'h800000, 24'h800000, 24'h7fffff, 7000, 24'hffffff,
              0, 0, 16'hffff, 0, 16'hffff, 0);
    send_word(0, 0, 0, 0, 1, 24'h000001, 1, 1, 0, 16'hffff, 0, 16'hffff);

    // Pause until the pipeline drains
    start <= 1'b0;
    while (board.pending_corners.size() != 0) @(posedge clk);

    // Random, with a stretch of back-to-back words in the middle
    for (int i = 0; i < 700; i++) begin
      idle_pct = (i >= 250 && i < 400) ? 0 : 37;
      send_random();
    end
    start <= 1'b0;

    while (board.pending_corners.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    $display("Sent %0d words (directed extremes, quadrants, folds, zero zoom, saturation,",
             words_sent);
    $display("random geometry); checked %0d result words.", board.checked);
    if (board.errors == 0 && board.pending_corners.size() == 0)
      $display("tb_rotated_rect_corner_transform: PASS");
    else
      $display("tb_rotated_rect_corner_transform: FAIL");
    $finish;
  end
endmodule
`default_nettype wire
